>>> sv/bdlp_pkg.sv
// Shared constants and types for the button debounce / long-press block.
`timescale 1ns / 1ps
package bdlp_pkg;

  localparam int unsigned NUM_BUTTONS_DEF = 4;   // default lane count
  localparam int unsigned IN_BTN_W        = 4;   // button levels carried by one request
  localparam int unsigned TIME_W          = 32;  // millisecond timestamp
  localparam int unsigned CFG_W           = 16;  // width of each config register
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned PCT_W           = 7;
  localparam int unsigned PCT_MAX         = 100;
  localparam int unsigned PCT_MUL_W       = 7;   // bits of the constant 100
  localparam int unsigned NUM_W           = TIME_W + PCT_MUL_W;  // elapsed * 100
  localparam int unsigned IN_TDATA_W      = 40;
  localparam int unsigned OUT_TDATA_W     = 24;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] PROG_START_RST = 16'd300;
  localparam logic [CFG_W-1:0] SLEEP_TRIG_RST = 16'd1800;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_PROG_START = 2'd1,
    REG_SLEEP_TRIG = 2'd2
  } cfg_reg_e;

  // Power key events of one scan
  typedef struct packed {
    logic overlay_shown;
    logic open;
    logic valid;
    logic sleep;
    logic close;
    logic back;
  } pwr_evt_t;

endpackage

>>> sv/bdlp_lane.sv
// One button lane: edge capture, press timestamp and debounced flag.
`timescale 1ns / 1ps
module bdlp_lane
  import bdlp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              level_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic [CFG_W-1:0]  debounce_i,
  output logic              flag_o
);

  logic              last_q, last_d;
  logic              flag_q, flag_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [TIME_W-1:0] held;

  always_comb begin
    held    = now_i - start_q;
    last_d  = level_i;
    start_d = start_q;
    flag_d  = flag_q;
    if (level_i && !last_q) begin
      start_d = now_i;
      flag_d  = 1'b0;
    end else if (level_i && !flag_q) begin
      if (held >= TIME_W'(debounce_i)) flag_d = 1'b1;
    end else if (!level_i) begin
      flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= 1'b0;
      flag_q  <= 1'b0;
      start_q <= '0;
    end else if (en_i) begin
      last_q  <= last_d;
      flag_q  <= flag_d;
      start_q <= start_d;
    end
  end

  assign flag_o = flag_q;

endmodule

>>> sv/bdlp_power.sv
// Power key hold tracking: overlay, sleep, close and back events.
`timescale 1ns / 1ps
module bdlp_power
  import bdlp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              level_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic [CFG_W-1:0]  debounce_i,
  input  logic [CFG_W-1:0]  prog_start_i,
  input  logic [CFG_W-1:0]  sleep_trig_i,
  output pwr_evt_t          evt_o,
  output logic [TIME_W-1:0] elapsed_o
);

  logic              last_q;
  logic              ostart_q, ostart_d, ostart_eff;
  logic              trig_q, trig_d, trig_eff;
  logic              shown_q, shown_d, shown_eff;
  logic [TIME_W-1:0] start_q, start_eff;
  logic [TIME_W-1:0] dur, elapsed;
  logic              rise, fall;
  pwr_evt_t          evt_d, evt_q;
  logic [TIME_W-1:0] elapsed_q;

  always_comb begin
    rise       = level_i & ~last_q;
    fall       = ~level_i & last_q;
    start_eff  = rise ? now_i : start_q;
    ostart_eff = rise ? 1'b0 : ostart_q;
    trig_eff   = rise ? 1'b0 : trig_q;
    shown_eff  = rise ? 1'b0 : shown_q;
    dur        = now_i - start_eff;
    elapsed    = dur - TIME_W'(prog_start_i);
    evt_d      = '0;
    ostart_d   = ostart_eff;
    trig_d     = trig_eff;
    shown_d    = shown_eff;
    if (level_i) begin
      if (!ostart_eff && dur >= TIME_W'(prog_start_i)) begin
        ostart_d   = 1'b1;
        shown_d    = 1'b1;
        evt_d.open = 1'b1;
      end
      if (ostart_d && !trig_eff) begin
        evt_d.valid = 1'b1;
        if (dur >= TIME_W'(sleep_trig_i)) begin
          trig_d      = 1'b1;
          shown_d     = 1'b0;
          evt_d.sleep = 1'b1;
        end
      end
    end
    if (fall) begin
      evt_d.close = ostart_q & ~trig_q;
      evt_d.back  = ~ostart_q & (dur >= TIME_W'(debounce_i));
      ostart_d    = 1'b0;
      trig_d      = 1'b0;
      shown_d     = 1'b0;
    end
    evt_d.overlay_shown = shown_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= 1'b0;
      start_q   <= '0;
      ostart_q  <= 1'b0;
      trig_q    <= 1'b0;
      shown_q   <= 1'b0;
      evt_q     <= '0;
      elapsed_q <= '0;
    end else if (en_i) begin
      last_q    <= level_i;
      start_q   <= start_eff;
      ostart_q  <= ostart_d;
      trig_q    <= trig_d;
      shown_q   <= shown_d;
      evt_q     <= evt_d;
      elapsed_q <= elapsed;
    end
  end

  assign evt_o     = evt_q;
  assign elapsed_o = elapsed_q;

endmodule

>>> sv/bdlp_div.sv
// Restoring divider, one quotient bit per cycle, result capped at 100.
`timescale 1ns / 1ps
module bdlp_div
  import bdlp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [CFG_W-1:0] den_i,
  output logic             done_o,
  output logic [PCT_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CFG_W-1:0] rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [CFG_W:0]   trial, diff;
  logic             qbit;

  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = trial - {1'b0, den_i};
    qbit  = (trial >= {1'b0, den_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
        rem_q  <= '0;
        quo_q  <= num_i;
      end else if (busy_q) begin
        rem_q <= qbit ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], qbit};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = ((|quo_q[NUM_W-1:PCT_W]) || (quo_q[PCT_W-1:0] > PCT_W'(PCT_MAX)))
                  ? PCT_W'(PCT_MAX) : quo_q[PCT_W-1:0];

endmodule

>>> sv/button_debounce_long_press_top.sv
// Top level of the button debounce and power key long-press detector.
`timescale 1ns / 1ps
// One request is one scan: a 32-bit millisecond timestamp, the levels of four
// buttons and the power key level. Each request yields exactly one result.
// Every button has its own lane that captures the press time on a rising edge
// and sets its debounced flag once the hold (modulo 2^32) reaches debounce_ms;
// the lanes work side by side in the accept cycle and their flags are merged
// into pressed_flags. The power key logic opens the progress overlay, reports
// the hold percent, requests sleep and flags close or back on release. The
// block takes one request at a time: a scan without a percent to compute
// goes from the evaluate state straight to the output state, while a scan
// that reports progress waits for the one-bit-per-cycle divider to work
// through the 39-bit product elapsed*100. The output register lets the next
// request enter while a result waits to be taken. Config registers
// (0 debounce_ms, 1 progress_start_ms, 2 sleep_trigger_ms) are written by
// cfg_we_i and must only change while no request is in flight.
module button_debounce_long_press_top
  import bdlp_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = NUM_BUTTONS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] time_ms, [35:32] button_levels, [36] power_level, [39:37] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [3:0] pressed_flags, [4] overlay_active, [5] overlay_open,
  // [6] progress_valid, [13:7] progress_percent, [14] sleep_request,
  // [15] overlay_close, [16] back_action, [23:17] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,  // power events registered, load divider
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q;

  // Config registers
  logic [CFG_W-1:0] deb_q, prog_q, trig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q  <= DEBOUNCE_RST;
      prog_q <= PROG_START_RST;
      trig_q <= SLEEP_TRIG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEBOUNCE:   deb_q  <= cfg_wdata_i;
        REG_PROG_START: prog_q <= cfg_wdata_i;
        REG_SLEEP_TRIG: trig_q <= cfg_wdata_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  logic              accept;
  logic [TIME_W-1:0] now;
  logic [IN_BTN_W-1:0] levels;
  logic              pwr;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign now           = s_axis_tdata[TIME_W-1:0];
  assign levels        = s_axis_tdata[TIME_W +: IN_BTN_W];
  assign pwr           = s_axis_tdata[TIME_W + IN_BTN_W];

  // Button lanes
  logic [NUM_BUTTONS-1:0] lane_flag;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic lvl;
    if (i < IN_BTN_W) begin : g_in
      assign lvl = levels[i];
    end else begin : g_none
      assign lvl = 1'b0;  // not wired to the scan, reads released
    end
    bdlp_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (accept),
      .level_i    (lvl),
      .now_i      (now),
      .debounce_i (deb_q),
      .flag_o     (lane_flag[i])
    );
  end

  // Merge lane flags into the reported field
  logic [IN_BTN_W-1:0] flags;

  for (genvar j = 0; j < IN_BTN_W; j++) begin : g_merge
    if (j < NUM_BUTTONS) begin : g_used
      assign flags[j] = lane_flag[j];
    end else begin : g_unused
      assign flags[j] = 1'b0;
    end
  end

  // Power key
  pwr_evt_t          evt;
  logic [TIME_W-1:0] elapsed;

  bdlp_power u_power (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept),
    .level_i      (pwr),
    .now_i        (now),
    .debounce_i   (deb_q),
    .prog_start_i (prog_q),
    .sleep_trig_i (trig_q),
    .evt_o        (evt),
    .elapsed_o    (elapsed)
  );

  // Percent divider: elapsed*100 / (trigger - start)
  logic             win_ok;
  logic [CFG_W-1:0] window;
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num;
  logic [PCT_W-1:0] div_quot;

  assign win_ok    = (trig_q > prog_q);
  assign window    = trig_q - prog_q;
  assign div_start = (state_q == S_EVAL) && evt.valid && win_ok;
  assign div_num   = NUM_W'(elapsed) * NUM_W'(PCT_MAX);

  bdlp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (window),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequencer and output register
  logic [PCT_W-1:0]       pct_q;
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic [OUT_TDATA_W-1:0] result;

  assign result = OUT_TDATA_W'({evt.back, evt.close, evt.sleep, pct_q, evt.valid,
                                evt.open, evt.overlay_shown, flags});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pct_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (evt.valid && win_ok) begin
            state_q <= S_DIV;
          end else begin
            pct_q   <= evt.valid ? PCT_W'(PCT_MAX) : '0;
            state_q <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pct_q   <= div_quot;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= result;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

>>> sv/bdlp_chk.sv
// Port-level checker for the debounce / long-press block, bound to the top.
`timescale 1ns / 1ps
module bdlp_chk
  import bdlp_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // Percent in range, and zero unless reported
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[13:7] <= 7'd100) &&
                      (m_axis_tdata[6] || m_axis_tdata[13:7] == 7'd0))
    else $error("bad progress percent");

  // Sleep comes with a progress report and hides the overlay
  a_sleep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[14] |-> m_axis_tdata[6] && !m_axis_tdata[4] &&
                                          !m_axis_tdata[15] && !m_axis_tdata[16])
    else $error("sleep request inconsistent");

  // Close and back exclude each other and leave the overlay down
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[15] || m_axis_tdata[16]) |->
      !(m_axis_tdata[15] && m_axis_tdata[16]) && !m_axis_tdata[4] && !m_axis_tdata[5])
    else $error("release events inconsistent");

endmodule

bind button_debounce_long_press_top bdlp_chk u_bdlp_chk (.*);
